// ===== design/ebm_pkg.sv =====
// ----------------------------------------------------------------------------
// ebm_pkg
// shared types, constants and codes of the extent block mapper
// ----------------------------------------------------------------------------
package ebm_pkg;

	// table geometry
	localparam int MAX_EXTENTS = 16;
	localparam int IDX_W       = (MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1;
	localparam int N_W         = $clog2(MAX_EXTENTS + 1);

	// field widths
	localparam int CFG_W   = 5;
	localparam int SLOT_W  = 4;
	localparam int BLK_W   = 24;
	localparam int LEN_W   = 8;
	localparam int PB_W    = 25;
	localparam int STS_W   = 2;

	// action codes
	localparam logic ACT_LOAD = 1'b0;
	localparam logic ACT_MAP  = 1'b1;

	// result status codes
	typedef enum logic [STS_W-1:0] {
		ST_MAPPED = 2'd0,
		ST_HOLE   = 2'd1,
		ST_EOF    = 2'd2
	} map_status_t;

	// one table entry
	typedef struct packed {
		logic [BLK_W-1:0] offset;
		logic [LEN_W-1:0] length;
		logic [BLK_W-1:0] start;
	} extent_t;

	// controller to datapath
	typedef struct packed {
		logic load;     // write one entry from the input item
		logic start;    // latch lookup block, clear scan index
		logic set_eof;  // empty scan, result is end of file
		logic check;    // evaluate the entry read, latch the result
		logic next;     // advance scan index
		logic emit;     // move result into the output register
	} ebm_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic n_zero;   // no entries to scan
		logic hit;      // current entry decides the lookup
		logic last;     // current entry is the last one to scan
		logic out_free; // output register can take a result
	} ebm_sts_t;

endpackage

// ===== design/ebm_ctrl.sv =====
// ----------------------------------------------------------------------------
// ebm_ctrl
// sequencer for load and map items: read, check, emit
// ----------------------------------------------------------------------------
module ebm_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              action,
	output logic              in_stall,
	input  ebm_pkg::ebm_sts_t sts,
	output ebm_pkg::ebm_cmd_t cmd
);
	import ebm_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_READ  = 4'b0010,
		S_CHECK = 4'b0100,
		S_EMIT  = 4'b1000
	} state_t;

	state_t state_q;
	state_t state_nxt;
	logic   accept;

	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid && !in_stall;

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (action == ACT_MAP) begin
						if (sts.n_zero) begin
							cmd.set_eof = 1'b1;
							state_nxt   = S_EMIT;
						end else begin
							cmd.start = 1'b1;
							state_nxt = S_READ;
						end
					end else begin
						cmd.load = 1'b1;
					end
				end
			end
			S_READ: begin
				state_nxt = S_CHECK;
			end
			S_CHECK: begin
				cmd.check = 1'b1;
				if (sts.hit || sts.last) begin
					state_nxt = S_EMIT;
				end else begin
					cmd.next  = 1'b1;
					state_nxt = S_READ;
				end
			end
			S_EMIT: begin
				if (sts.out_free) begin
					cmd.emit  = 1'b1;
					state_nxt = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

// ===== design/ebm_dpath.sv =====
// ----------------------------------------------------------------------------
// ebm_dpath
// extent table, scan index, entry compare and output register
// ----------------------------------------------------------------------------
module ebm_dpath (
	input  logic                       clk,
	input  logic                       arst_n,
	input  ebm_pkg::ebm_cmd_t          cmd,
	output ebm_pkg::ebm_sts_t          sts,
	input  logic                       cfg_wr,
	input  logic [ebm_pkg::CFG_W-1:0]  cfg_data,
	input  logic [ebm_pkg::SLOT_W-1:0] entry_index,
	input  logic [ebm_pkg::BLK_W-1:0]  extent_offset,
	input  logic [ebm_pkg::LEN_W-1:0]  extent_length,
	input  logic [ebm_pkg::BLK_W-1:0]  extent_start,
	input  logic [ebm_pkg::BLK_W-1:0]  logical_block,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [ebm_pkg::STS_W-1:0]  map_status,
	output logic [ebm_pkg::PB_W-1:0]   physical_block
);
	import ebm_pkg::*;

	extent_t          mem [MAX_EXTENTS];
	extent_t          rd_q;

	logic [CFG_W-1:0] extents_in_use_q;
	logic [N_W-1:0]   n_sat;
	logic [N_W-1:0]   n_q;
	logic [IDX_W-1:0] idx_q;
	logic [BLK_W-1:0] lb_q;

	map_status_t      res_status_q;
	logic [BLK_W-1:0] res_base_q;
	logic [BLK_W-1:0] res_off_q;

	logic             out_valid_q;
	logic [STS_W-1:0] out_status_q;
	logic [PB_W-1:0]  out_pb_q;

	logic             lb_below;
	logic [BLK_W-1:0] off;
	logic             lb_within;
	logic             slot_ok;

	// saturate the scan count to the table size
	always_comb begin
		if (32'(extents_in_use_q) > MAX_EXTENTS) begin
			n_sat = N_W'(MAX_EXTENTS);
		end else begin
			n_sat = N_W'(extents_in_use_q);
		end
	end

	// entry compare
	assign lb_below  = lb_q < rd_q.offset;
	assign off       = lb_q - rd_q.offset;
	assign lb_within = (off[BLK_W-1:LEN_W] == '0) && (off[LEN_W-1:0] < rd_q.length);
	assign slot_ok   = 32'(entry_index) < MAX_EXTENTS;

	assign sts.n_zero   = (n_sat == '0);
	assign sts.hit      = lb_below || lb_within;
	assign sts.last     = (N_W'(idx_q) + N_W'(1)) == n_q;
	assign sts.out_free = !out_valid_q || !out_stall;

	// extent table
	always_ff @(posedge clk) begin
		if (cmd.load && slot_ok) begin
			mem[IDX_W'(entry_index)] <= '{offset: extent_offset, length: extent_length,
				start: extent_start};
		end
		rd_q <= mem[idx_q];
	end

	// scan state and result
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			lb_q <= logical_block;
			n_q  <= n_sat;
		end
		if (cmd.start) begin
			idx_q <= '0;
		end else if (cmd.next) begin
			idx_q <= idx_q + IDX_W'(1);
		end
		if (cmd.set_eof) begin
			res_status_q <= ST_EOF;
		end else if (cmd.check) begin
			if (lb_below) begin
				res_status_q <= ST_HOLE;
			end else if (lb_within) begin
				res_status_q <= ST_MAPPED;
			end else begin
				res_status_q <= ST_EOF;
			end
			res_base_q <= rd_q.start;
			res_off_q  <= off;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q      <= 1'b0;
			extents_in_use_q <= '0;
		end else begin
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_wr) begin
				extents_in_use_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_status_q <= res_status_q;
			if (res_status_q == ST_MAPPED) begin
				out_pb_q <= PB_W'(res_base_q) + PB_W'(res_off_q);
			end else begin
				out_pb_q <= '0;
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign map_status     = out_status_q;
	assign physical_block = out_pb_q;

endmodule

// ===== design/extent_block_mapper.sv =====
// ----------------------------------------------------------------------------
// extent_block_mapper
// file extent table with in-order lookup of logical to physical blocks
// ----------------------------------------------------------------------------
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+----------------------------------
//  in      | in        | in_valid / in_stall   | action, entry_index, extent_*,
//          |           |                       | logical_block
//  out     | out       | out_valid / out_stall | map_status, physical_block
//  cfg     | in        | cfg_valid / cfg_ready | cfg_data (extents_in_use)
//
//  a load item writes one table entry and gives no result
//  a map item visits k entries, k at most extents_in_use, capped at the
//  table size; each entry costs a table read state and a compare state on
//  the single read port
//  the output register holds a result while out_stall is high; the next item
//  is taken as soon as the result is in that register
//  arst_n clears the sequencer, output valid and extents_in_use; table
//  contents are not cleared and read as garbage until written
// ----------------------------------------------------------------------------
module extent_block_mapper (
	input  logic                       clk,
	input  logic                       arst_n,
	// item input
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic                       action,
	input  logic [ebm_pkg::SLOT_W-1:0] entry_index,
	input  logic [ebm_pkg::BLK_W-1:0]  extent_offset,
	input  logic [ebm_pkg::LEN_W-1:0]  extent_length,
	input  logic [ebm_pkg::BLK_W-1:0]  extent_start,
	input  logic [ebm_pkg::BLK_W-1:0]  logical_block,
	// result output
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [ebm_pkg::STS_W-1:0]  map_status,
	output logic [ebm_pkg::PB_W-1:0]   physical_block,
	// configuration write
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [ebm_pkg::CFG_W-1:0]  cfg_data
);
	import ebm_pkg::*;

	ebm_cmd_t cmd;
	ebm_sts_t sts;

	// register write is always taken
	assign cfg_ready = 1'b1;

	// sequencer: idle, table read, compare, result hand-off
	ebm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.action   (action),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// table, scan index, compare and output register
	ebm_dpath u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.cfg_wr         (cfg_valid && cfg_ready),
		.cfg_data       (cfg_data),
		.entry_index    (entry_index),
		.extent_offset  (extent_offset),
		.extent_length  (extent_length),
		.extent_start   (extent_start),
		.logical_block  (logical_block),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.map_status     (map_status),
		.physical_block (physical_block)
	);

endmodule

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the extent block mapper: loads extent tables,
// mostly sorted with random gaps and lengths and sometimes scrambled, then
// maps logical blocks aimed inside, before, between and past the extents.
// Each result is checked against a local model of the table and the scan
// count, under random idle cycles on both sides and one long output stall.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import ebm_pkg::*;

	localparam int CLK_PERIOD   = 12;
	localparam int ITEM_TARGET  = 1350;
	// covers the longest map item, a scan of MAX_EXTENTS entries, plus margin
	localparam int DRAIN_CYCLES = 2 * MAX_EXTENTS + 10;
	// one long output stall so the block backs up into its input
	localparam int HOLD_AT      = 150;
	localparam int HOLD_CYCLES  = 400;
	// stretches with no idling on either side
	localparam int SEND_CALM_LO = 400;
	localparam int SEND_CALM_HI = 650;
	localparam int RECV_CALM_LO = 500;
	localparam int RECV_CALM_HI = 700;

	// one expected lookup result
	typedef struct packed {
		map_status_t      status;
		logic [PB_W-1:0]  block;
	} lookup_result_t;

	// shadow of the extent table and scan count, plus the lookups in flight
	class extent_lookup_board;
		extent_t          extents [MAX_EXTENTS];
		logic [CFG_W-1:0] scan_limit;
		lookup_result_t   lookups_due [$];
		int               mismatches;

		function new();
			scan_limit = '0;
			mismatches = 0;
		endfunction

		// in-order scan of the first scan_limit entries
		function lookup_result_t predict_lookup(logic [BLK_W-1:0] lb);
			lookup_result_t   r;
			int unsigned      n;
			logic [BLK_W-1:0] delta;
			r.status = ST_EOF;
			r.block  = '0;
			// counts above the table size saturate
			n = (scan_limit > MAX_EXTENTS) ? MAX_EXTENTS : scan_limit;
			for (int i = 0; i < n; i++) begin
				// block lies before this extent: hole
				if (lb < extents[i].offset) begin
					r.status = ST_HOLE;
					break;
				end
				// zero length never matches, the scan moves on
				delta = lb - extents[i].offset;
				if (delta < BLK_W'(extents[i].length)) begin
					r.status = ST_MAPPED;
					r.block  = PB_W'(extents[i].start) + PB_W'(delta);
					break;
				end
			end
			return r;
		endfunction

		function void note_item(logic act, logic [SLOT_W-1:0] slot,
				logic [BLK_W-1:0] offset, logic [LEN_W-1:0] len,
				logic [BLK_W-1:0] start, logic [BLK_W-1:0] lb);
			if (act == ACT_LOAD) begin
				// slots past the table are dropped
				if (slot < MAX_EXTENTS) begin
					extents[slot].offset = offset;
					extents[slot].length = len;
					extents[slot].start  = start;
				end
			end else begin
				lookups_due.push_back(predict_lookup(lb));
			end
		endfunction

		function void check_result(logic [STS_W-1:0] sts, logic [PB_W-1:0] blk);
			lookup_result_t want;
			if (lookups_due.size() == 0) begin
				$display("%0t: unexpected result, status %0d block 0x%0h",
					$time, sts, blk);
				mismatches++;
				return;
			end
			want = lookups_due.pop_front();
			if (sts !== want.status) begin
				$display("%0t: map_status expected %0d actual %0d",
					$time, want.status, sts);
				mismatches++;
			end
			if (blk !== want.block) begin
				$display("%0t: physical_block expected 0x%0h actual 0x%0h",
					$time, want.block, blk);
				mismatches++;
			end
		endfunction

		function int pending();
			return lookups_due.size();
		endfunction
	endclass

	// clock and reset
	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	// item input, all driven from time zero
	logic              in_valid      = 1'b0;
	logic              in_stall;
	logic              action        = ACT_LOAD;
	logic [SLOT_W-1:0] entry_index   = '0;
	logic [BLK_W-1:0]  extent_offset = '0;
	logic [LEN_W-1:0]  extent_length = '0;
	logic [BLK_W-1:0]  extent_start  = '0;
	logic [BLK_W-1:0]  logical_block = '0;

	// result output
	logic              out_valid;
	logic              out_stall     = 1'b0;
	logic [STS_W-1:0]  map_status;
	logic [PB_W-1:0]   physical_block;

	// configuration write
	logic              cfg_valid     = 1'b0;
	logic              cfg_ready;
	logic [CFG_W-1:0]  cfg_data      = '0;

	extent_lookup_board board = new();
	int items_sent   = 0;
	int results_seen = 0;
	int hold_left    = 0;

	extent_block_mapper dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.action         (action),
		.entry_index    (entry_index),
		.extent_offset  (extent_offset),
		.extent_length  (extent_length),
		.extent_start   (extent_start),
		.logical_block  (logical_block),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.map_status     (map_status),
		.physical_block (physical_block),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_data       (cfg_data)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// offer one item, hold it until taken, then record it
	task automatic put_item(logic act, logic [SLOT_W-1:0] slot,
			logic [BLK_W-1:0] off, logic [LEN_W-1:0] len,
			logic [BLK_W-1:0] st, logic [BLK_W-1:0] lb);
		bit quiet;
		quiet = (items_sent >= SEND_CALM_LO) && (items_sent < SEND_CALM_HI);
		// random idle cycles ahead of the item
		while (!quiet && $urandom_range(99) < 8) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid      <= 1'b1;
		action        <= act;
		entry_index   <= slot;
		extent_offset <= off;
		extent_length <= len;
		extent_start  <= st;
		logical_block <= lb;
		@(posedge clk);
		// in_stall read here is the value the block saw at this edge
		while (in_stall) @(posedge clk);
		board.note_item(act, slot, off, len, st, lb);
		items_sent++;
	endtask

	// load item, the lookup field carries noise
	task automatic put_load(logic [SLOT_W-1:0] slot, logic [BLK_W-1:0] off,
			logic [LEN_W-1:0] len, logic [BLK_W-1:0] st);
		put_item(ACT_LOAD, slot, off, len, st, BLK_W'($urandom));
	endtask

	// map item, the load fields carry noise
	task automatic put_map(logic [BLK_W-1:0] lb);
		put_item(ACT_MAP, SLOT_W'($urandom), BLK_W'($urandom), LEN_W'($urandom),
			BLK_W'($urandom), lb);
	endtask

	// change the scan count only with the block idle
	task automatic set_extents_in_use(logic [CFG_W-1:0] count);
		in_valid <= 1'b0;
		while (board.pending() != 0) @(posedge clk);
		// a trailing load gives no result, so allow a full scan time
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= count;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		board.scan_limit = count;
	endtask

	// lookup block aimed at the live part of the table
	function automatic logic [BLK_W-1:0] pick_block();
		int unsigned      live;
		extent_t          e;
		extent_t          tail;
		logic [BLK_W-1:0] lb;
		live = (board.scan_limit > MAX_EXTENTS) ? MAX_EXTENTS : board.scan_limit;
		if (live == 0)
			return BLK_W'($urandom);
		e    = board.extents[$urandom_range(live - 1)];
		tail = board.extents[live - 1];
		case ($urandom_range(9))
			0, 1, 2, 3, 4: begin
				// inside the extent
				lb = (e.length == 0) ? e.offset
					: e.offset + BLK_W'($urandom_range(e.length - 1));
			end
			5: lb = e.offset - 1'b1;                  // just before it
			6: lb = e.offset + BLK_W'(e.length);      // one past its end
			7: lb = tail.offset + BLK_W'(tail.length) + BLK_W'($urandom_range(4095));
			8: lb = BLK_W'($urandom);
			default: lb = $urandom_range(1) ? '1 : '0;
		endcase
		return lb;
	endfunction

	// one setting of the scan count, a fresh table, then a burst of lookups
	task automatic run_phase();
		int unsigned      pick;
		int unsigned      cursor;
		int unsigned      gap;
		int unsigned      j;
		int               order [MAX_EXTENTS];
		int               swap;
		bit               sorted;
		logic [BLK_W-1:0] offs [MAX_EXTENTS];
		logic [LEN_W-1:0] lens [MAX_EXTENTS];
		logic [BLK_W-1:0] starts [MAX_EXTENTS];

		pick = $urandom_range(9);
		case (pick)
			0: set_extents_in_use(CFG_W'(0));
			1: set_extents_in_use(CFG_W'(MAX_EXTENTS));
			2: set_extents_in_use('1);
			3: set_extents_in_use(CFG_W'($urandom_range(MAX_EXTENTS + 1, 31)));
			default: set_extents_in_use(CFG_W'($urandom_range(1, MAX_EXTENTS)));
		endcase

		// mostly ascending extents, sometimes scrambled
		sorted = $urandom_range(9) < 8;
		cursor = $urandom_range(24'hFFFFFF) >> $urandom_range(23);
		for (int i = 0; i < MAX_EXTENTS; i++) begin
			case ($urandom_range(19))
				0, 1, 2, 3, 4:        gap = 0;
				5, 6, 7, 8, 9, 10, 11: gap = $urandom_range(1, 16);
				12, 13, 14, 15, 16:   gap = $urandom_range(1, 4096);
				default:              gap = $urandom_range(20'hFFFFF);
			endcase
			offs[i] = sorted ? BLK_W'(cursor + gap) : BLK_W'($urandom);
			case ($urandom_range(9))
				0:       lens[i] = '0;
				1:       lens[i] = '1;
				default: lens[i] = LEN_W'($urandom_range(1, 255));
			endcase
			starts[i] = ($urandom_range(7) == 0) ? '1 - BLK_W'($urandom_range(255))
				: BLK_W'($urandom);
			cursor = cursor + gap + lens[i];
			order[i] = i;
		end

		// load the slots in random order
		for (int i = MAX_EXTENTS - 1; i > 0; i--) begin
			j = $urandom_range(i);
			swap = order[i];
			order[i] = order[j];
			order[j] = swap;
		end
		for (int i = 0; i < MAX_EXTENTS; i++)
			put_load(SLOT_W'(order[i]), offs[order[i]], lens[order[i]], starts[order[i]]);

		// lookups, with an odd rewrite of a random slot
		repeat ($urandom_range(20, 60)) begin
			if ($urandom_range(19) == 0)
				put_load(SLOT_W'($urandom), BLK_W'($urandom), LEN_W'($urandom),
					BLK_W'($urandom));
			else
				put_map(pick_block());
		end
	endtask

	// stimulus
	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// every slot written first, so no lookup ever reads garbage
		put_load(4'd0, 24'h000000, 8'd0, 24'h123456);   // zero length at block 0
		put_load(4'd1, 24'h000000, 8'd255, 24'hFFFFFF); // mapped block spills into bit 24
		put_load(4'd2, 24'h000100, 8'd1, 24'h000000);
		for (int i = 3; i < MAX_EXTENTS - 1; i++)
			put_load(SLOT_W'(i), BLK_W'(i * 24'h1000), LEN_W'(i * 17),
				BLK_W'(i * 24'h10101));
		put_load(4'd15, 24'hFFFFFF, 8'd255, 24'hFFFFFF);

		// scan count still at its reset value of zero: end of file
		put_map(24'h000000);
		put_map(24'hFFFFFF);

		// full table: skip past zero length, map, hole, map at the top
		set_extents_in_use(CFG_W'(MAX_EXTENTS));
		put_map(24'h000000);
		put_map(24'h0000FE);
		put_map(24'h0000FF);
		put_map(24'h000100);
		put_map(24'hFFFFFF);

		// counts above the table size saturate
		set_extents_in_use(CFG_W'(MAX_EXTENTS + 1));
		put_map(24'hFFFFFF);
		set_extents_in_use('1);
		put_map(24'h000101);

		// single entry of zero length: end of file
		set_extents_in_use(CFG_W'(1));
		put_map(24'h000100);

		while (items_sent < ITEM_TARGET)
			run_phase();

		// drain, then allow for any stray result
		in_valid <= 1'b0;
		while (board.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (board.mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	// result side: check each accepted result, then pick the next stall
	initial begin
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall) begin
				board.check_result(map_status, physical_block);
				results_seen++;
				if (results_seen == HOLD_AT)
					hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				// long hold-off, the sender keeps offering
				hold_left--;
				out_stall <= 1'b1;
			end else if (!(results_seen >= RECV_CALM_LO && results_seen < RECV_CALM_HI)
					&& $urandom_range(99) < 8) begin
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// hang guard
	initial begin
		#10_000_000;
		$display("status: fail");
		$finish;
	end

endmodule

// ===== extent_block_mapper.f =====
design/ebm_pkg.sv
design/ebm_ctrl.sv
design/ebm_dpath.sv
design/extent_block_mapper.sv
test/tb_top.sv
